// ===== sv/mbe_pkg.sv =====
// Shared types, constants and saturating arithmetic for the Mandelbrot escape-time block.
package mbe_pkg;

  localparam int unsigned FRAC_BITS_DEFAULT = 28;
  localparam int unsigned VAL_W = 64;
  localparam int unsigned HALF_W = VAL_W / 2;
  localparam int unsigned PT_W = 32;
  localparam int unsigned CNT_W = 16;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(256);
  localparam logic [0:0] REG_ITER_LIMIT = 1'b0;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic signed [PT_W-1:0] pt_t;

  localparam val_t VAL_MAX = val_t'({1'b0, {(VAL_W-1){1'b1}}});
  localparam val_t VAL_MIN = val_t'({1'b1, {(VAL_W-1){1'b0}}});

  typedef struct packed {
    logic start;
    logic half;
    val_t a;
    val_t b;
  } mul_req_t;

  typedef struct packed {
    pt_t  re;
    pt_t  im;
    logic in_set;
  } point_t;

  function automatic val_t sat_add(val_t x, val_t y);
    logic [VAL_W:0] sum;
    sum = {x[VAL_W-1], x} + {y[VAL_W-1], y};
    if (sum[VAL_W] != sum[VAL_W-1]) begin
      sat_add = sum[VAL_W] ? VAL_MIN : VAL_MAX;
    end else begin
      sat_add = val_t'(sum[VAL_W-1:0]);
    end
  endfunction

  function automatic val_t sext_pt(pt_t v);
    sext_pt = val_t'({{(VAL_W-PT_W){v[PT_W-1]}}, v});
  endfunction

endpackage

// ===== sv/mbe_mul.sv =====
// Iterative saturating fixed-point multiplier built from four 32x32 partial products.
module mbe_mul #(
  parameter int unsigned FRAC_BITS = mbe_pkg::FRAC_BITS_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mbe_pkg::mul_req_t req_i,
  output logic              done_o,
  output mbe_pkg::val_t     res_o
);
  import mbe_pkg::*;

  localparam int unsigned ShF = FRAC_BITS;
  localparam int unsigned ShH = FRAC_BITS - 1;
  localparam int unsigned ProdW = 2 * VAL_W;
  localparam logic [2:0] StepLastPp = 3'd3;
  localparam logic [2:0] StepFin = 3'd5;

  logic [VAL_W-1:0] a_u, b_u, abs_a, abs_b;
  logic [VAL_W-1:0] ua_q, ub_q;
  logic             neg_q, half_q;
  logic             active_q, done_q;
  logic [2:0]       cnt_q;
  logic [HALF_W-1:0] pa, pb;
  logic [VAL_W-1:0] pp, prod_q;
  logic [1:0]       off, off_q;
  logic [ProdW-1:0] acc_q, addend;
  logic [ProdW-1:0] mag_f, mag_h, mag;
  logic             rem_f, rem_h, rem_nz, hi_nz;
  logic [VAL_W:0]   lo_inc;
  val_t             fin, res_q;

  assign a_u = req_i.a;
  assign b_u = req_i.b;
  assign abs_a = a_u[VAL_W-1] ? (~a_u + VAL_W'(1)) : a_u;
  assign abs_b = b_u[VAL_W-1] ? (~b_u + VAL_W'(1)) : b_u;

  assign pa = cnt_q[1] ? ua_q[VAL_W-1:HALF_W] : ua_q[HALF_W-1:0];
  assign pb = cnt_q[0] ? ub_q[VAL_W-1:HALF_W] : ub_q[HALF_W-1:0];
  assign pp = {{HALF_W{1'b0}}, pa} * {{HALF_W{1'b0}}, pb};
  assign off = {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};

  always_comb begin
    case (off_q)
      2'd0:    addend = {{VAL_W{1'b0}}, prod_q};
      2'd1:    addend = {{HALF_W{1'b0}}, prod_q, {HALF_W{1'b0}}};
      2'd2:    addend = {prod_q, {VAL_W{1'b0}}};
      default: addend = '0;
    endcase
  end

  assign mag_f = acc_q >> ShF;
  assign mag_h = acc_q >> ShH;
  assign rem_f = |acc_q[ShF-1:0];
  assign rem_h = |acc_q[ShH-1:0];
  assign mag = half_q ? mag_h : mag_f;
  assign rem_nz = half_q ? rem_h : rem_f;
  assign hi_nz = |mag[ProdW-1:VAL_W];
  assign lo_inc = {1'b0, mag[VAL_W-1:0]} + {{VAL_W{1'b0}}, neg_q & rem_nz};

  always_comb begin
    if (neg_q) begin
      if (hi_nz || lo_inc[VAL_W] || lo_inc[VAL_W-1]) begin
        fin = VAL_MIN;
      end else begin
        fin = -val_t'(lo_inc[VAL_W-1:0]);
      end
    end else begin
      if (hi_nz || mag[VAL_W-1]) begin
        fin = VAL_MAX;
      end else begin
        fin = val_t'(mag[VAL_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= active_q && (cnt_q == StepFin);
      if (req_i.start) begin
        active_q <= 1'b1;
        cnt_q <= '0;
      end else if (active_q) begin
        if (cnt_q == StepFin) begin
          active_q <= 1'b0;
        end
        cnt_q <= cnt_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      ua_q <= abs_a;
      ub_q <= abs_b;
      neg_q <= a_u[VAL_W-1] ^ b_u[VAL_W-1];
      half_q <= req_i.half;
      acc_q <= '0;
    end else if (active_q) begin
      if (cnt_q <= StepLastPp) begin
        prod_q <= pp;
        off_q <= off;
      end
      if (cnt_q != 3'd0 && cnt_q != StepFin) begin
        acc_q <= acc_q + addend;
      end
      if (cnt_q == StepFin) begin
        res_q <= fin;
      end
    end
  end

  assign done_o = done_q;
  assign res_o = res_q;

endmodule

// ===== sv/mbe_queue.sv =====
// Short queue of classified points between the front and back parts.
module mbe_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mbe_pkg::point_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output mbe_pkg::point_t data_o,
  output logic            empty_o
);
  import mbe_pkg::*;

  localparam int unsigned IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  point_t          mem_q [QUEUE_DEPTH];
  logic [IdxW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o = (cnt_q == CntW'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && !empty_o;
  assign data_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == IdxW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + IdxW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == IdxW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + IdxW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== sv/mbe_front.sv =====
// Front part: accepts points and runs the main-cardioid test.
module mbe_front #(
  parameter int unsigned FRAC_BITS = mbe_pkg::FRAC_BITS_DEFAULT
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  mbe_pkg::pt_t    point_real_i,
  input  mbe_pkg::pt_t    point_imag_i,
  output logic            busy,
  output logic            push_o,
  output mbe_pkg::point_t point_o,
  input  logic            full_i
);
  import mbe_pkg::*;

  localparam logic [2:0] FsIdle = 3'd0;
  localparam logic [2:0] FsSqGo = 3'd1;
  localparam logic [2:0] FsSqWait = 3'd2;
  localparam logic [2:0] FsLhsGo = 3'd3;
  localparam logic [2:0] FsLhsWait = 3'd4;
  localparam logic [2:0] FsPush = 3'd5;

  localparam val_t Quarter = val_t'(64'd1 << (FRAC_BITS - 2));

  logic [2:0] state_q, state_d;
  pt_t        cre_q, cim_q;
  val_t       a_q, im2_q, q_q, s_q;
  logic       inside_q;
  mul_req_t   req0, req1;
  logic       done0, done1;
  val_t       res0, res1, q_sum, s_sum;

  assign req0.start = (state_q == FsSqGo) || (state_q == FsLhsGo);
  assign req0.half = 1'b0;
  assign req0.a = (state_q == FsLhsGo) ? q_q : a_q;
  assign req0.b = (state_q == FsLhsGo) ? s_q : a_q;

  assign req1.start = (state_q == FsSqGo);
  assign req1.half = 1'b0;
  assign req1.a = sext_pt(cim_q);
  assign req1.b = sext_pt(cim_q);

  mbe_mul #(.FRAC_BITS(FRAC_BITS)) u_mul0 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req0),
    .done_o (done0),
    .res_o  (res0)
  );

  mbe_mul #(.FRAC_BITS(FRAC_BITS)) u_mul1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req1),
    .done_o (done1),
    .res_o  (res1)
  );

  assign q_sum = sat_add(res0, res1);
  assign s_sum = sat_add(q_sum, a_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      FsIdle:    if (start) state_d = FsSqGo;
      FsSqGo:    state_d = FsSqWait;
      FsSqWait:  if (done0 && done1) state_d = FsLhsGo;
      FsLhsGo:   state_d = FsLhsWait;
      FsLhsWait: if (done0) state_d = FsPush;
      FsPush:    if (!full_i) state_d = FsIdle;
      default:   state_d = FsIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FsIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == FsIdle && start) begin
      cre_q <= point_real_i;
      cim_q <= point_imag_i;
      a_q <= sext_pt(point_real_i) - Quarter;
    end
    if (state_q == FsSqWait && done0 && done1) begin
      im2_q <= res1;
      q_q <= q_sum;
      s_q <= s_sum;
    end
    if (state_q == FsLhsWait && done0) begin
      inside_q <= (res0 < (im2_q >>> 2));
    end
  end

  assign busy = (state_q != FsIdle);
  assign push_o = (state_q == FsPush) && !full_i;
  assign point_o.re = cre_q;
  assign point_o.im = cim_q;
  assign point_o.in_set = inside_q;

endmodule

// ===== sv/mbe_back.sv =====
// Back part: iterates z = z*z + c on queued points and emits the escape count.
module mbe_back #(
  parameter int unsigned FRAC_BITS = mbe_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [mbe_pkg::CNT_W-1:0] limit_i,
  input  logic                      empty_i,
  input  mbe_pkg::point_t           point_i,
  output logic                      pop_o,
  output logic                      done_o,
  output logic [mbe_pkg::CNT_W-1:0] escape_count_o
);
  import mbe_pkg::*;

  localparam logic [1:0] BsIdle = 2'd0;
  localparam logic [1:0] BsGo = 2'd1;
  localparam logic [1:0] BsWait = 2'd2;

  localparam val_t Bound = val_t'(64'd4 << FRAC_BITS);

  logic [1:0]       state_q, state_d;
  val_t             cre_q, cim_q, zr_q, zi_q;
  logic [CNT_W-1:0] n_q, n_inc;
  logic             done_q, done_d;
  logic [CNT_W-1:0] count_q, count_d;
  mul_req_t         req0, req1, req2;
  logic             done0, done1, done2;
  val_t             res0, res1, res2, mag2;
  logic             escaped, exhausted, early;

  assign req0 = '{start: state_q == BsGo, half: 1'b0, a: zr_q, b: zr_q};
  assign req1 = '{start: state_q == BsGo, half: 1'b0, a: zi_q, b: zi_q};
  assign req2 = '{start: state_q == BsGo, half: 1'b1, a: zr_q, b: zi_q};

  mbe_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_rr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req0),
    .done_o (done0),
    .res_o  (res0)
  );

  mbe_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_ii (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req1),
    .done_o (done1),
    .res_o  (res1)
  );

  mbe_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_ri (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req2),
    .done_o (done2),
    .res_o  (res2)
  );

  assign pop_o = (state_q == BsIdle) && !empty_i;
  assign early = point_i.in_set || (limit_i == '0);
  assign mag2 = sat_add(res0, res1);
  assign n_inc = n_q + CNT_W'(1);
  assign escaped = (mag2 > Bound);
  assign exhausted = (n_inc == limit_i);

  always_comb begin
    state_d = state_q;
    done_d = 1'b0;
    count_d = count_q;
    case (state_q)
      BsIdle: begin
        if (!empty_i) begin
          if (early) begin
            done_d = 1'b1;
            count_d = '0;
          end else begin
            state_d = BsGo;
          end
        end
      end
      BsGo: state_d = BsWait;
      BsWait: begin
        if (done0 && done1 && done2) begin
          if (escaped) begin
            done_d = 1'b1;
            count_d = n_inc;
            state_d = BsIdle;
          end else if (exhausted) begin
            done_d = 1'b1;
            count_d = '0;
            state_d = BsIdle;
          end else begin
            state_d = BsGo;
          end
        end
      end
      default: state_d = BsIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BsIdle;
      done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    count_q <= count_d;
    if (pop_o) begin
      cre_q <= sext_pt(point_i.re);
      cim_q <= sext_pt(point_i.im);
      zr_q <= sext_pt(point_i.re);
      zi_q <= sext_pt(point_i.im);
      n_q <= '0;
    end else if (state_q == BsWait && done0 && done1 && done2) begin
      n_q <= n_inc;
      zr_q <= sat_add(sat_add(res0, -res1), cre_q);
      zi_q <= sat_add(res2, cim_q);
    end
  end

  assign done_o = done_q;
  assign escape_count_o = count_q;

endmodule

// ===== sv/mandelbrot_escape_time.sv =====
// Top level of the Mandelbrot escape-time block with its configuration register.
//
// Usage: drive point_real_i and point_imag_i (signed fixed point, FRAC_BITS
// fraction bits) and raise start; the beat is taken at an edge where start is
// high and busy is low. The result appears on escape_count_o, marked by done_o
// high for exactly one cycle; results leave in the order points came in.
// The receiver cannot stall, so no result is ever held back.
// The front runs the main-cardioid test and then hands the point to a
// two-entry queue, so while the back iterates it takes new points as long as
// the queue has room. Each back iteration waits on the 64-bit iterative
// multipliers (four 32x32 partial products each); a point caught by the
// cardioid test or a limit of zero leaves from the queue without iterating.
// iteration_limit sits at APB byte address 0; write it only while idle.
// Reset clears the queue and both control paths and sets the limit to 256.
module mandelbrot_escape_time #(
  parameter int unsigned FRAC_BITS = mbe_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  mbe_pkg::pt_t                   point_real_i,
  input  mbe_pkg::pt_t                   point_imag_i,
  output logic                           done_o,
  output logic [mbe_pkg::CNT_W-1:0]      escape_count_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mbe_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [mbe_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [mbe_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import mbe_pkg::*;

  logic [CNT_W-1:0] limit_q;
  logic             reg_sel, cfg_wr;
  logic             push, full, pop, empty;
  point_t           push_pt, pop_pt;

  assign pready = 1'b1;
  assign reg_sel = (paddr[CFG_ADDR_W-1:2] == REG_ITER_LIMIT);
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = reg_sel ? {{(CFG_DATA_W-CNT_W){1'b0}}, limit_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_wr && reg_sel) begin
      limit_q <= pwdata[CNT_W-1:0];
    end
  end

  mbe_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .point_real_i (point_real_i),
    .point_imag_i (point_imag_i),
    .busy         (busy),
    .push_o       (push),
    .point_o      (push_pt),
    .full_i       (full)
  );

  mbe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_pt),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (pop_pt),
    .empty_o (empty)
  );

  mbe_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .limit_i        (limit_q),
    .empty_i        (empty),
    .point_i        (pop_pt),
    .pop_o          (pop),
    .done_o         (done_o),
    .escape_count_o (escape_count_o)
  );

endmodule
